// ===== rtl/base64_stream_encoder_unit_macros.svh =====
// assertion macros used by the encoder checker
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define B64SE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define B64SE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/b64se_pkg.sv =====
// types and constants shared by the base64 stream encoder
package b64se_pkg;

    localparam int CODE_W   = 6;
    localparam int NCODES   = 4;
    localparam int ALPHA_N  = 64;
    localparam int CHAR_W   = 8;
    localparam int GPL_W    = 6;
    localparam int GPS_W    = 4;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 6;
    localparam int IN_DW    = 16;
    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;

    localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_NL  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SP  = 8'h20;

    localparam logic [GPL_W-1:0] GPL_RESET = 6'd12;
    localparam logic [GPS_W-1:0] GPS_RESET = 4'd2;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_ALPHA = 1'b1;

    localparam logic [CFG_AW-1:0] CFG_GPL = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_GPS = 1'b1;

    localparam logic [1:0] NPAD_NONE = 2'd0;
    localparam logic [1:0] NPAD_ONE  = 2'd1;
    localparam logic [1:0] NPAD_TWO  = 2'd2;

    typedef struct packed {
        logic [NCODES-1:0][CODE_W-1:0] codes;
        logic [1:0]                    npad;
        logic                          nl;
        logic                          sp;
        logic                          eom;
    } t_grp;

    typedef struct packed {
        logic              full;
        logic              empty;
    } t_q_stat;

    typedef struct packed {
        logic              we;
        logic [CODE_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } t_alpha_wr;

    typedef struct packed {
        logic              re;
        logic [CODE_W-1:0] addr;
    } t_alpha_rd;

endpackage

// ===== rtl/base64_stream_encoder_unit.sv =====
// Streaming base64 encoder with a loadable 64-entry alphabet. Each input beat
// carries one raw byte (tuser low) or one alphabet entry write (tuser high);
// tlast on a data beat ends the message and flushes a padded tail. Data beats
// are taken every cycle while the queue has room; once it is full, every data
// beat waits for the back end to take a record. A completed group becomes a
// record in a four-deep queue; the back end turns each record into four to six
// characters at one per cycle while the output port takes them, one alphabet
// ram read per code character that is not a pad, so the sustained input rate
// is set by the single character output port. A completed group is held in the
// queue, then the record register; its characters pass the read stage and the
// output register. An alphabet write is held off until the queue and the back
// end have drained, so load the alphabet before the data. Output tlast marks the
// last character of an input beat, tuser the last character of the message.
module base64_stream_encoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [b64se_pkg::IN_DW-1:0]  s_axis_tdata,  // data_byte[7:0], alphabet_index[13:8]
    input  logic                         s_axis_tuser,  // func
    input  logic                         s_axis_tlast,  // message_end
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [b64se_pkg::CHAR_W-1:0] m_axis_tdata,  // out_char[7:0]
    output logic                         m_axis_tlast,  // run_last
    output logic                         m_axis_tuser,  // message_done
    input  logic                         i_cfg_we,
    input  logic [b64se_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [b64se_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import b64se_pkg::*;

    t_q_stat           w_q_stat;
    t_grp              w_push_grp, w_head_grp;
    logic              w_push, w_pop, w_back_busy;
    t_alpha_wr         w_alpha_wr;
    t_alpha_rd         w_alpha_rd;
    logic [CHAR_W-1:0] w_rd_data;

    b64se_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_stat      (w_q_stat),
        .i_back_busy   (w_back_busy),
        .o_push        (w_push),
        .o_grp         (w_push_grp),
        .o_alpha_wr    (w_alpha_wr)
    );

    b64se_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_push_grp),
        .i_pop   (w_pop),
        .o_grp   (w_head_grp),
        .o_stat  (w_q_stat)
    );

    b64se_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (ALPHA_N)
    ) u_alpha_ram (
        .i_clk   (i_clk),
        .i_we    (w_alpha_wr.we),
        .i_waddr (w_alpha_wr.addr),
        .i_wdata (w_alpha_wr.data),
        .i_re    (w_alpha_rd.re),
        .i_raddr (w_alpha_rd.addr),
        .o_rdata (w_rd_data)
    );

    b64se_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (w_q_stat),
        .i_grp         (w_head_grp),
        .o_pop         (w_pop),
        .o_busy        (w_back_busy),
        .o_rd          (w_alpha_rd),
        .i_rd_data     (w_rd_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/b64se_ram.sv =====
// generic simple dual-port ram with registered read
module b64se_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/b64se_front.sv =====
// front end: accepts beats, holds bytes, counts groups, queues group records and issues alphabet writes
module b64se_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [b64se_pkg::IN_DW-1:0] s_axis_tdata,  // data_byte[7:0], alphabet_index[13:8]
    input  logic                        s_axis_tuser,  // func
    input  logic                        s_axis_tlast,  // message_end
    input  logic                        i_cfg_we,
    input  logic [b64se_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [b64se_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  b64se_pkg::t_q_stat          i_q_stat,
    input  logic                        i_back_busy,
    output logic                        o_push,
    output b64se_pkg::t_grp             o_grp,
    output b64se_pkg::t_alpha_wr        o_alpha_wr
);
    import b64se_pkg::*;

    logic [GPL_W-1:0]  r_gpl;
    logic [GPS_W-1:0]  r_gps;
    logic [1:0]        r_phase, n_phase;
    logic [CHAR_W-1:0] r_b0, r_b1;
    logic [GPL_W-1:0]  r_line, n_line;
    logic [GPS_W-1:0]  r_space, n_space;

    logic              w_alpha;
    logic              w_acc;
    logic              w_data_acc;
    logic              w_full;
    logic              w_end;
    logic [CHAR_W-1:0] w_b;
    logic [CHAR_W-1:0] w_x0, w_x1, w_x2;
    logic              w_nl, w_sp;
    logic [GPS_W-1:0]  w_sp_next;
    logic [GPL_W-1:0]  w_line_base;

    assign w_alpha = (s_axis_tuser == FUNC_ALPHA);
    assign s_axis_tready = w_alpha ? (i_q_stat.empty && !i_back_busy) : !i_q_stat.full;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_data_acc = w_acc && !w_alpha;
    assign w_b = s_axis_tdata[CHAR_W-1:0];
    assign w_end = s_axis_tlast;
    assign w_full = r_phase[1];

    // byte lanes of the group, zero where a tail has no byte
    assign w_x0 = (r_phase == 2'd0) ? w_b : r_b0;
    assign w_x1 = (r_phase == 2'd1) ? w_b : (w_full ? r_b1 : '0);
    assign w_x2 = w_full ? w_b : '0;

    assign w_nl        = w_full && (r_line >= r_gpl);
    assign w_sp_next   = GPS_W'(r_space + 4'd1);
    assign w_sp        = w_full && (w_sp_next >= r_gps);
    assign w_line_base = w_nl ? '0 : r_line;

    always_comb begin
        o_grp.codes[0] = w_x0[7:2];
        o_grp.codes[1] = {w_x0[1:0], w_x1[7:4]};
        o_grp.codes[2] = {w_x1[3:0], w_x2[7:6]};
        o_grp.codes[3] = w_x2[5:0];
        o_grp.npad     = w_full ? NPAD_NONE : ((r_phase == 2'd1) ? NPAD_ONE : NPAD_TWO);
        o_grp.nl       = w_nl;
        o_grp.sp       = w_sp;
        o_grp.eom      = w_end;
    end

    assign o_push = w_data_acc && (w_full || w_end);

    assign o_alpha_wr.we   = w_acc && w_alpha;
    assign o_alpha_wr.addr = s_axis_tdata[CHAR_W +: CODE_W];
    assign o_alpha_wr.data = w_b;

    always_comb begin
        n_phase = r_phase;
        n_line  = r_line;
        n_space = r_space;
        if (w_data_acc) begin
            if (w_end) begin
                n_phase = '0;
                n_line  = '0;
                n_space = '0;
            end else if (w_full) begin
                n_phase = '0;
                n_line  = GPL_W'(w_line_base + 6'd1);
                n_space = w_sp ? '0 : w_sp_next;
            end else begin
                n_phase = 2'(r_phase + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl   <= GPL_RESET;
            r_gps   <= GPS_RESET;
            r_phase <= '0;
            r_line  <= '0;
            r_space <= '0;
        end else begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_space <= n_space;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_GPL: r_gpl <= i_cfg_wdata[GPL_W-1:0];
                    CFG_GPS: r_gps <= i_cfg_wdata[GPS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_acc && !w_end && !w_full) begin
            if (r_phase[0]) begin
                r_b1 <= w_b;
            end else begin
                r_b0 <= w_b;
            end
        end
    end

endmodule

// ===== rtl/b64se_fifo.sv =====
// short queue of group records between front and back
module b64se_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b64se_pkg::t_grp    i_grp,
    input  logic               i_pop,
    output b64se_pkg::t_grp    o_grp,
    output b64se_pkg::t_q_stat o_stat
);
    import b64se_pkg::*;

    t_grp             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QAW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QAW'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= (QAW+1)'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= (QAW+1)'(r_cnt - 1'b1);
            end
        end
    end

    assign o_grp        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/b64se_back.sv =====
// back end: steps through each group record and emits one character per beat
module b64se_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  b64se_pkg::t_q_stat           i_q_stat,
    input  b64se_pkg::t_grp              i_grp,
    output logic                         o_pop,
    output logic                         o_busy,
    output b64se_pkg::t_alpha_rd         o_rd,
    input  logic [b64se_pkg::CHAR_W-1:0] i_rd_data,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [b64se_pkg::CHAR_W-1:0] m_axis_tdata,  // out_char[7:0]
    output logic                         m_axis_tlast,  // run_last
    output logic                         m_axis_tuser   // message_done
);
    import b64se_pkg::*;

    localparam logic [2:0] SLOT_NL = 3'd0;
    localparam logic [2:0] SLOT_C0 = 3'd1;
    localparam logic [2:0] SLOT_C1 = 3'd2;
    localparam logic [2:0] SLOT_C2 = 3'd3;
    localparam logic [2:0] SLOT_C3 = 3'd4;
    localparam logic [2:0] SLOT_SP = 3'd5;

    logic              r_busy;
    logic [2:0]        r_slot;
    t_grp              r_grp;

    logic              r_b_vld;
    logic              r_b_ram;
    logic [CHAR_W-1:0] r_b_lit;
    logic              r_b_last;
    logic              r_b_done;

    logic              r_o_vld;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_last;
    logic              r_o_done;

    logic              w_out_ld, w_b_adv, w_issue;
    logic [1:0]        w_k;
    logic              w_pad, w_code, w_last;
    logic [CHAR_W-1:0] w_lit;

    assign w_out_ld = !r_o_vld || m_axis_tready;
    assign w_b_adv  = r_b_vld && w_out_ld;
    assign w_issue  = r_busy && (!r_b_vld || w_b_adv);

    assign w_k   = 2'(r_slot - SLOT_C0);
    assign w_pad = ((r_grp.npad == NPAD_TWO) && w_k[1])
                || ((r_grp.npad == NPAD_ONE) && (w_k == 2'd3));
    assign w_last = (r_slot == SLOT_SP) || ((r_slot == SLOT_C3) && !r_grp.sp);

    always_comb begin
        w_code = 1'b0;
        w_lit  = CHAR_PAD;
        unique case (r_slot)
            SLOT_NL: w_lit = CHAR_NL;
            SLOT_SP: w_lit = CHAR_SP;
            SLOT_C0, SLOT_C1, SLOT_C2, SLOT_C3: w_code = !w_pad;
            default: ;
        endcase
    end

    assign o_rd.re   = w_issue && w_code;
    assign o_rd.addr = r_grp.codes[w_k];

    assign o_pop  = !i_q_stat.empty && (!r_busy || (w_issue && w_last));
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_slot  <= SLOT_NL;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_slot <= i_grp.nl ? SLOT_NL : SLOT_C0;
            end else if (w_issue) begin
                r_busy <= !w_last;
                r_slot <= 3'(r_slot + 3'd1);
            end
            if (w_issue) begin
                r_b_vld <= 1'b1;
            end else if (w_b_adv) begin
                r_b_vld <= 1'b0;
            end
            if (w_b_adv) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_grp;
        end
        if (w_issue) begin
            r_b_ram  <= w_code;
            r_b_lit  <= w_lit;
            r_b_last <= w_last;
            r_b_done <= w_last && r_grp.eom;
        end
        if (w_b_adv) begin
            r_o_char <= r_b_ram ? i_rd_data : r_b_lit;
            r_o_last <= r_b_last;
            r_o_done <= r_b_done;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_char;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_done;

endmodule

// ===== rtl/b64se_chk.sv =====
// port-level checker for the encoder and its bind
`include "base64_stream_encoder_unit_macros.svh"

module b64se_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [b64se_pkg::CHAR_W-1:0] m_axis_tdata,
    input logic                         m_axis_tlast,
    input logic                         m_axis_tuser
);

    // a stalled beat keeps its character and flags
    `B64SE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output beat changed")

    // the end of a message is always the end of its input beat's run
    `B64SE_ASSERT(a_done_is_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "message_done without run_last")

    // reset empties the output stage
    `B64SE_ASSERT_RST(a_rst_clears, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind base64_stream_encoder_unit b64se_chk u_chk (.*);

// ===== sim/tb_top.sv =====
// self-checking testbench for the base64 stream encoder unit
`timescale 1ns / 100ps

module tb_top;
    import b64se_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              beat_end;
        logic              msg_end;
    } t_enc_char;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata;
    logic                s_axis_tuser;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [CHAR_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_wdata;

    // encoder state as the testbench sees it
    logic [CHAR_W-1:0]   alpha_tbl [ALPHA_N];
    logic [7:0]          held_b [2];
    logic [1:0]          byte_cnt;
    logic [GPL_W-1:0]    line_grps;
    logic [GPS_W-1:0]    space_grps;
    logic [GPL_W-1:0]    grps_per_line;
    logic [GPS_W-1:0]    grps_per_space;

    t_enc_char           pending_chars [$];
    t_enc_char           exp_c;
    int                  err_cnt;
    int                  stall_cycles;
    int                  tx_gap_max;
    int                  rx_gap_max;
    int                  hold_len;

    base64_stream_encoder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic void clear_message();
        held_b[0]  = '0;
        held_b[1]  = '0;
        byte_cnt   = '0;
        line_grps  = '0;
        space_grps = '0;
    endfunction

    // works out the characters one accepted beat gives and queues them, or updates its table copy on an alphabet write
    function automatic void encode_beat(input logic func, input logic [7:0] byte_v,
                                        input logic [CODE_W-1:0] idx, input logic eom);
        logic [CHAR_W-1:0] seq [$];
        logic [7:0]        b0;
        logic [7:0]        b1;
        t_enc_char         c;
        if (func == FUNC_ALPHA) begin
            alpha_tbl[idx] = byte_v;
            return;
        end
        if (byte_cnt >= 2) begin
            b0 = held_b[0];
            b1 = held_b[1];
            if (line_grps >= grps_per_line) begin
                seq.push_back(CHAR_NL);
                line_grps = '0;
            end
            seq.push_back(alpha_tbl[b0[7:2]]);
            seq.push_back(alpha_tbl[{b0[1:0], b1[7:4]}]);
            seq.push_back(alpha_tbl[{b1[3:0], byte_v[7:6]}]);
            seq.push_back(alpha_tbl[byte_v[5:0]]);
            space_grps = space_grps + 1'b1;
            if (space_grps >= grps_per_space) begin
                seq.push_back(CHAR_SP);
                space_grps = '0;
            end
            line_grps = line_grps + 1'b1;
            byte_cnt  = '0;
            held_b[0] = '0;
            held_b[1] = '0;
        end else if (!eom) begin
            held_b[byte_cnt[0]] = byte_v;
            byte_cnt = byte_cnt + 1'b1;
        end else if (byte_cnt == 0) begin
            seq.push_back(alpha_tbl[byte_v[7:2]]);
            seq.push_back(alpha_tbl[{byte_v[1:0], 4'b0000}]);
            seq.push_back(CHAR_PAD);
            seq.push_back(CHAR_PAD);
        end else begin
            b0 = held_b[0];
            seq.push_back(alpha_tbl[b0[7:2]]);
            seq.push_back(alpha_tbl[{b0[1:0], byte_v[7:4]}]);
            seq.push_back(alpha_tbl[{byte_v[3:0], 2'b00}]);
            seq.push_back(CHAR_PAD);
        end
        foreach (seq[k]) begin
            c.ch       = seq[k];
            c.beat_end = (k == seq.size() - 1);
            c.msg_end  = (k == seq.size() - 1) && eom;
            pending_chars.push_back(c);
        end
        if (eom) begin
            clear_message();
        end
    endfunction

    task automatic send_beat(input logic func, input logic [7:0] byte_v,
                             input logic [CODE_W-1:0] idx, input logic eom);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, byte_v};
        s_axis_tuser  <= func;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_beat(func, byte_v, idx, eom);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == CFG_GPL) begin
            grps_per_line = val[GPL_W-1:0];
        end else begin
            grps_per_space = val[GPS_W-1:0];
        end
    endtask

    // messages of random length and content, with the odd alphabet rewrite
    task automatic run_messages(input int n_items, input int min_len, input int max_len);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(min_len, max_len);
            if (len > left) begin
                len = left;
            end
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_beat(FUNC_ALPHA, 8'($urandom), 6'($urandom), 1'($urandom));
                end
                send_beat(FUNC_DATA, 8'($urandom), 6'($urandom), k == len - 1);
            end
            left -= len;
        end
        wait_drained();
    endtask

    task automatic test_load_alphabet();
        string std_alpha;
        std_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        tx_gap_max = 3;
        rx_gap_max = 3;
        for (int i = 0; i < ALPHA_N; i++) begin
            send_beat(FUNC_ALPHA, std_alpha[i], 6'(i), 1'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_directed();
        tx_gap_max = 10;
        rx_gap_max = 10;
        // reset layout: one-byte tail, two-byte tail, full groups
        send_beat(FUNC_DATA, 8'hFF, 6'h00, 1'b1);
        send_beat(FUNC_DATA, 8'h00, 6'h3F, 1'b0);
        send_beat(FUNC_DATA, 8'hFF, 6'h00, 1'b1);
        send_beat(FUNC_DATA, 8'hA5, 6'h15, 1'b0);
        send_beat(FUNC_DATA, 8'h5A, 6'h2A, 1'b0);
        send_beat(FUNC_DATA, 8'hC3, 6'h00, 1'b0);
        // table write mid message, its tlast has no effect
        send_beat(FUNC_ALPHA, "/", 6'h3F, 1'b1);
        // message closed by a full group, done lands on the space
        send_beat(FUNC_DATA, 8'h01, 6'h00, 1'b0);
        send_beat(FUNC_DATA, 8'h02, 6'h00, 1'b0);
        send_beat(FUNC_DATA, 8'h03, 6'h00, 1'b1);
        wait_drained();
        cfg_write(CFG_GPL, 6'd1);
        cfg_write(CFG_GPS, 6'd1);
        for (int k = 0; k < 6; k++) begin
            send_beat(FUNC_DATA, 8'($urandom), 6'($urandom), k == 5);
        end
        wait_drained();
        // zero registers: newline before every group, space after each
        cfg_write(CFG_GPL, 6'd0);
        cfg_write(CFG_GPS, 6'd0);
        for (int k = 0; k < 6; k++) begin
            send_beat(FUNC_DATA, 8'($urandom), 6'($urandom), k == 5);
        end
        wait_drained();
    endtask

    task automatic test_long_lines();
        cfg_write(CFG_GPL, 6'd63);
        cfg_write(CFG_GPS, 6'd15);
        tx_gap_max = 10;
        rx_gap_max = 10;
        run_messages(200, 195, 200);
    endtask

    task automatic test_tight_layout();
        cfg_write(CFG_GPL, 6'd1);
        cfg_write(CFG_GPS, 6'h3F);
        cfg_write(CFG_GPS, 6'd1);
        tx_gap_max = 0;
        rx_gap_max = 0;
        run_messages(30, 1, 12);
    endtask

    task automatic test_random_layout();
        for (int r = 0; r < 3; r++) begin
            cfg_write(CFG_GPL, 6'($urandom_range(1, 63)));
            cfg_write(CFG_GPS, {2'($urandom), 4'($urandom_range(1, 15))});
            tx_gap_max = (r == 1) ? 0 : 10;
            rx_gap_max = (r == 2) ? 0 : 10;
            run_messages(10, 1, 20);
        end
    endtask

    task automatic test_output_backpressure();
        cfg_write(CFG_GPL, 6'd4);
        cfg_write(CFG_GPS, 6'd2);
        tx_gap_max = 0;
        rx_gap_max = 2;
        hold_len   = 300;
        run_messages(30, 30, 30);
    endtask

    // receiver: random ready gaps, plus one long hold on request
    initial begin : rx_side
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                report_error($sformatf("unexpected char %02h last %b done %b",
                                       m_axis_tdata, m_axis_tlast, m_axis_tuser));
            end else begin
                exp_c = pending_chars.pop_front();
                if (m_axis_tdata !== exp_c.ch || m_axis_tlast !== exp_c.beat_end ||
                    m_axis_tuser !== exp_c.msg_end) begin
                    report_error($sformatf(
                        "char exp %02h/%b/%b got %02h/%b/%b (char/last/done)",
                        exp_c.ch, exp_c.beat_end, exp_c.msg_end,
                        m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("** base64_stream_encoder_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_DATA;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_GPL;
        i_cfg_wdata   = '0;
        err_cnt       = 0;
        stall_cycles  = 0;
        tx_gap_max    = 0;
        rx_gap_max    = 0;
        hold_len      = 0;
        foreach (alpha_tbl[i]) alpha_tbl[i] = '0;
        clear_message();
        grps_per_line  = GPL_RESET;
        grps_per_space = GPS_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_alphabet();
        test_directed();
        test_long_lines();
        test_tight_layout();
        test_random_layout();
        test_output_backpressure();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            report_error($sformatf("%0d chars never arrived", pending_chars.size()));
        end
        if (err_cnt == 0) begin
            $display("** base64_stream_encoder_unit: PASSED **");
        end else begin
            $display("** base64_stream_encoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
